@@ rtl/rbchp_pkg.sv @@
// shared types, constants and fixed-point helpers of the ray/box closest-hit picker
`default_nettype none

package rbchp_pkg;

    localparam int BoxIdW        = 16;
    localparam int CoordW        = 32;
    localparam int SizeW         = 31;
    localparam int LimitW        = 31;
    localparam int DistW         = 32;
    localparam int ProdW         = 2 * CoordW;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 32;
    localparam int IdBitsDefault = 16;
    localparam int PipeDepth     = 5;
    localparam int ResFifoDepth  = 8;

    localparam logic [CoordW-1:0] OriginReset = 32'd0;
    localparam logic [CoordW-1:0] RecipReset  = 32'd65536;
    localparam logic [LimitW-1:0] LimitReset  = 31'd655360000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_ORIGIN_Z       = 3'd2,
        CFG_RECIP_DIR_X    = 3'd3,
        CFG_RECIP_DIR_Y    = 3'd4,
        CFG_RECIP_DIR_Z    = 3'd5,
        CFG_DISTANCE_LIMIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [BoxIdW-1:0]        box_id;
        logic signed [CoordW-1:0] centre_x;
        logic signed [CoordW-1:0] centre_y;
        logic signed [CoordW-1:0] centre_z;
        logic [SizeW-1:0]         size_x;
        logic [SizeW-1:0]         size_y;
        logic [SizeW-1:0]         size_z;
        logic                     last_box;
    } t_box;

    typedef struct packed {
        logic                    hit_found;
        logic [BoxIdW-1:0]       nearest_id;
        logic signed [DistW-1:0] nearest_distance;
    } t_hit;

    // saturate a 34-bit difference to signed 32
    function automatic logic signed [CoordW-1:0] sat_diff(input logic signed [CoordW+1:0] v);
        logic signed [CoordW-1:0] r;
        if (v[CoordW+1:CoordW-1] == '0 || v[CoordW+1:CoordW-1] == '1) begin
            r = v[CoordW-1:0];
        end else if (v[CoordW+1]) begin
            r = {1'b1, {(CoordW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CoordW-1){1'b1}}};
        end
        return r;
    endfunction

    // Q32.32 product to Q16.16: floor by dropping 16 bits, then saturate
    function automatic logic signed [DistW-1:0] slab_scale(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-17:0] q;
        logic signed [DistW-1:0]  r;
        q = p[ProdW-1:16];
        if (q[ProdW-17:DistW-1] == '0 || q[ProdW-17:DistW-1] == '1) begin
            r = q[DistW-1:0];
        end else if (q[ProdW-17]) begin
            r = {1'b1, {(DistW-1){1'b0}}};
        end else begin
            r = {1'b0, {(DistW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rbchp_if.sv @@
// valid/ready channel interfaces for boxes in and pick results out
`default_nettype none

interface rbchp_box_if;
    import rbchp_pkg::*;
    logic valid;
    logic ready;
    t_box payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rbchp_hit_if;
    import rbchp_pkg::*;
    logic valid;
    logic ready;
    t_hit payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/ray_box_closest_hit_picker_unit.sv @@
// Takes one box per clock and runs a five-stage pipeline: input register, slab bound
// minus origin, one 32x32 multiply per slab bound, scaling and per-axis ordering, then
// the three-axis tmin/tmax reduction; the running nearest hit is compared and updated
// in the cycle after that, so only that one compare-and-select loop carries from box to
// box. A box marked last pushes its pick result into an eight-entry result queue when it
// leaves the reduction stage and clears the running state. Input ready is withheld
// only when last boxes in flight plus queued results would fill that queue, so with the
// output drained the block sustains one box every cycle. Configuration writes go
// straight to the registers and are meant for idle periods.
`default_nettype none

module ray_box_closest_hit_picker_unit #(
    parameter int ID_BITS = rbchp_pkg::IdBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rbchp_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [rbchp_pkg::CfgDataW-1:0] i_cfg_data,
    rbchp_box_if.sink                     i_box,
    rbchp_hit_if.source                   o_hit
);
    import rbchp_pkg::*;

    localparam int IdW  = (ID_BITS < BoxIdW) ? ID_BITS : BoxIdW;
    localparam int PtrW = $clog2(ResFifoDepth);
    localparam int CntW = PtrW + 1;
    localparam int SumW = $clog2(ResFifoDepth + PipeDepth + 1);

    // configuration
    logic signed [CoordW-1:0] r_org [3];
    logic signed [CoordW-1:0] r_rcp [3];
    logic [LimitW-1:0]        r_limit;
    logic [LimitW-1:0]        n_limit;

    // pipeline control
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic r_last0, r_last1, r_last2, r_last3, r_last4;
    logic [IdW-1:0] r_id0, r_id1, r_id2, r_id3, r_id4;

    // pipeline payload
    logic signed [CoordW-1:0] r_cen0 [3];
    logic [SizeW-1:0]         r_size0 [3];
    logic signed [CoordW-1:0] r_dlo1 [3];
    logic signed [CoordW-1:0] r_dhi1 [3];
    logic signed [ProdW-1:0]  r_plo2 [3];
    logic signed [ProdW-1:0]  r_phi2 [3];
    logic signed [DistW-1:0]  r_lo3 [3];
    logic signed [DistW-1:0]  r_hi3 [3];
    logic signed [DistW-1:0]  r_tmin4;
    logic signed [DistW-1:0]  r_tmax4;

    logic signed [CoordW-1:0] n_dlo [3];
    logic signed [CoordW-1:0] n_dhi [3];
    logic signed [DistW-1:0]  n_lo [3];
    logic signed [DistW-1:0]  n_hi [3];
    logic signed [DistW-1:0]  n_tmin;
    logic signed [DistW-1:0]  n_tmax;

    // running pick state
    logic                    r_any_hit;
    logic [IdW-1:0]          r_best_id;
    logic signed [DistW-1:0] r_best_dist;
    logic                    n_any_hit;
    logic [IdW-1:0]          n_best_id;
    logic signed [DistW-1:0] n_best_dist;
    logic                    hit;

    // result queue
    t_hit            r_fifo [ResFifoDepth];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_cnt;
    logic            push;
    logic            pop;
    logic [SumW-1:0] pending;
    t_hit            push_data;

    logic accept;

    assign accept = i_box.valid && i_box.ready;
    assign push   = r_v4 && r_last4;
    assign pop    = o_hit.valid && o_hit.ready;

    // every last box in flight holds a queue slot
    assign pending = SumW'(r_cnt)
                   + SumW'(r_v0 && r_last0) + SumW'(r_v1 && r_last1)
                   + SumW'(r_v2 && r_last2) + SumW'(r_v3 && r_last3)
                   + SumW'(r_v4 && r_last4);

    assign i_box.ready   = pending < SumW'(ResFifoDepth);
    assign o_hit.valid   = r_cnt != '0;
    assign o_hit.payload = r_fifo[r_rptr];

    // slab bounds relative to origin
    always_comb begin
        logic [SizeW-1:0]         half;
        logic signed [CoordW+1:0] lo_b;
        logic signed [CoordW+1:0] hi_b;
        for (int a = 0; a < 3; a++) begin
            half     = r_size0[a] >> 1;
            lo_b     = (CoordW+2)'(r_cen0[a]) - (CoordW+2)'(half) - (CoordW+2)'(r_org[a]);
            hi_b     = (CoordW+2)'(r_cen0[a]) + (CoordW+2)'(half) - (CoordW+2)'(r_org[a]);
            n_dlo[a] = sat_diff(lo_b);
            n_dhi[a] = sat_diff(hi_b);
        end
    end

    // scale and order the two slab distances of each axis
    always_comb begin
        logic signed [DistW-1:0] ta;
        logic signed [DistW-1:0] tb;
        for (int a = 0; a < 3; a++) begin
            ta      = slab_scale(r_plo2[a]);
            tb      = slab_scale(r_phi2[a]);
            n_lo[a] = (ta < tb) ? ta : tb;
            n_hi[a] = (ta < tb) ? tb : ta;
        end
    end

    always_comb begin
        n_tmin = (r_lo3[0] > r_lo3[1]) ? r_lo3[0] : r_lo3[1];
        if (r_lo3[2] > n_tmin) begin
            n_tmin = r_lo3[2];
        end
        n_tmax = (r_hi3[0] < r_hi3[1]) ? r_hi3[0] : r_hi3[1];
        if (r_hi3[2] < n_tmax) begin
            n_tmax = r_hi3[2];
        end
    end

    // nearest-hit update; ties keep the earlier box
    always_comb begin
        n_limit = r_limit;
        if (i_cfg_we && i_cfg_idx == CFG_DISTANCE_LIMIT) begin
            n_limit = i_cfg_data[LimitW-1:0];
        end
        hit = r_v4 && !r_tmax4[DistW-1] && (r_tmin4 <= r_tmax4) && (r_tmin4 < r_best_dist);
        n_any_hit   = r_any_hit || hit;
        n_best_id   = hit ? r_id4 : r_best_id;
        n_best_dist = hit ? r_tmin4 : r_best_dist;
        push_data.hit_found        = n_any_hit;
        push_data.nearest_id       = BoxIdW'(n_best_id);
        push_data.nearest_distance = n_best_dist;
        if (push) begin
            n_any_hit = 1'b0;
            n_best_id = '0;
        end
        // with nothing recorded the best distance tracks the limit
        if (!n_any_hit) begin
            n_best_dist = DistW'(n_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]    <= OriginReset;
            r_org[1]    <= OriginReset;
            r_org[2]    <= OriginReset;
            r_rcp[0]    <= RecipReset;
            r_rcp[1]    <= RecipReset;
            r_rcp[2]    <= RecipReset;
            r_limit     <= LimitReset;
            r_any_hit   <= 1'b0;
            r_best_id   <= '0;
            r_best_dist <= DistW'(LimitReset);
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_X:       r_org[0] <= i_cfg_data;
                    CFG_ORIGIN_Y:       r_org[1] <= i_cfg_data;
                    CFG_ORIGIN_Z:       r_org[2] <= i_cfg_data;
                    CFG_RECIP_DIR_X:    r_rcp[0] <= i_cfg_data;
                    CFG_RECIP_DIR_Y:    r_rcp[1] <= i_cfg_data;
                    CFG_RECIP_DIR_Z:    r_rcp[2] <= i_cfg_data;
                    CFG_DISTANCE_LIMIT: r_limit  <= n_limit;
                    default: ;
                endcase
            end
            r_any_hit   <= n_any_hit;
            r_best_id   <= n_best_id;
            r_best_dist <= n_best_dist;
            r_v0        <= accept;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(push) - CntW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id0      <= i_box.payload.box_id[IdW-1:0];
            r_last0    <= i_box.payload.last_box;
            r_cen0[0]  <= i_box.payload.centre_x;
            r_cen0[1]  <= i_box.payload.centre_y;
            r_cen0[2]  <= i_box.payload.centre_z;
            r_size0[0] <= i_box.payload.size_x;
            r_size0[1] <= i_box.payload.size_y;
            r_size0[2] <= i_box.payload.size_z;
        end
        r_id1   <= r_id0;
        r_id2   <= r_id1;
        r_id3   <= r_id2;
        r_id4   <= r_id3;
        r_last1 <= r_last0;
        r_last2 <= r_last1;
        r_last3 <= r_last2;
        r_last4 <= r_last3;
        for (int a = 0; a < 3; a++) begin
            r_dlo1[a] <= n_dlo[a];
            r_dhi1[a] <= n_dhi[a];
            r_plo2[a] <= r_dlo1[a] * r_rcp[a];
            r_phi2[a] <= r_dhi1[a] * r_rcp[a];
            r_lo3[a]  <= n_lo[a];
            r_hi3[a]  <= n_hi[a];
        end
        r_tmin4 <= n_tmin;
        r_tmax4 <= n_tmax;
        if (push) begin
            r_fifo[r_wptr] <= push_data;
        end
    end

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < CntW'(ResFifoDepth)))
        else $error("result queue full when a pick completes");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ResFifoDepth))
        else $error("result queue count out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (!r_any_hit && r_best_id == '0))
        else $error("pick state not cleared after last box");

    a_idle_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any_hit |-> (r_best_dist == DistW'(r_limit)))
        else $error("best distance differs from limit with no hit recorded");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any_hit |-> (r_best_id == '0))
        else $error("best id set with no hit recorded");

endmodule

`default_nettype wire
